// ----- design/ssc_pkg.sv -----
package ssc_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LENGTH_W = 12;

  // Special bytes
  localparam logic [BYTE_W-1:0] CTRL_C  = 8'h03;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SL   = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_BSL  = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_DQ   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQ   = 8'h27;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_STORE    = 3'd0,
    KIND_FORWARD  = 3'd1,
    KIND_RUN      = 3'd2,
    KIND_SAVE     = 3'd3,
    KIND_ERASE    = 3'd4,
    KIND_CLEARED  = 3'd5,
    KIND_STOPPED  = 3'd6,
    KIND_OVERFLOW = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    LX_PLAIN  = 2'd0,
    LX_STRLIT = 2'd1,
    LX_CHRLIT = 2'd2,
    LX_REMARK = 2'd3
  } lex_e;

  typedef enum logic [1:0] {
    LN_PREFIX       = 2'd0,
    LN_PREFIX_SLASH = 2'd1,
    LN_BODY         = 2'd2,
    LN_COMMENT      = 2'd3
  } line_e;

  // Control flags of the compactor
  typedef struct packed {
    logic       running;
    logic       ovf_rep;
    logic       swallow_lf;
    lex_e       lex;
    line_e      line;
    logic       esc;
    logic       slash;
    logic       cmd_allowed;
    logic [2:0] lcc;
    logic [2:0] cmatch;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    running:     1'b0,
    ovf_rep:     1'b0,
    swallow_lf:  1'b0,
    lex:         LX_PLAIN,
    line:        LN_PREFIX,
    esc:         1'b0,
    slash:       1'b0,
    cmd_allowed: 1'b1,
    lcc:         3'd0,
    cmatch:      3'b111
  };

  // One result word
  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    data;
    logic [LENGTH_W-1:0]  length;
    logic                 last;
  } res_t;

  // Command lines: @run, @save, @erase
  localparam int unsigned NUM_CMD = 3;
  localparam logic [2:0] CMD_LEN [NUM_CMD] = '{3'd4, 3'd5, 3'd6};
  localparam kind_e CMD_KIND [NUM_CMD] = '{KIND_RUN, KIND_SAVE, KIND_ERASE};
  localparam logic [BYTE_W-1:0] CMD_TEXT [NUM_CMD][6] = '{
    '{8'h40, 8'h72, 8'h75, 8'h6e, 8'h00, 8'h00},
    '{8'h40, 8'h73, 8'h61, 8'h76, 8'h65, 8'h00},
    '{8'h40, 8'h65, 8'h72, 8'h61, 8'h73, 8'h65}
  };

endpackage

// ----- design/script_source_compactor.sv -----
// Script source compactor. Takes one word per cycle on the slave side if ready:
// tuser is the mode (0 serial byte, 1 script start outcome), tdata holds the
// byte and the start flag. Each word yields zero to three result words on the
// master side (kind in tuser, byte and length in tdata, tlast on the final one).
// Every word is decoded and its state committed in the cycle it is accepted;
// results go into a four-entry output queue that drains one word per cycle
// while the master side is ready. A new word is taken whenever at most one
// result is waiting, so words with at most one result each stream at one per
// cycle when the master side is ready. Stored length is reported in 12 bits.
module script_source_compactor import ssc_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] start_ok, [15:9] zero
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data, [19:8] length, [23:20] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned QDEPTH = 4;

  logic       step;
  logic       pop;
  res_t [2:0] res;
  logic [1:0] res_cnt;

  res_t       q_mem [QDEPTH];
  logic [1:0] head_q, tail_q;
  logic [2:0] count_q;
  res_t       head;

  assign step = s_axis_tvalid & s_axis_tready;
  assign pop  = m_axis_tvalid & m_axis_tready;

  ssc_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .mode_i    (s_axis_tuser),
    .rx_byte_i (s_axis_tdata[7:0]),
    .start_ok_i(s_axis_tdata[8]),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  // Write the results of an accepted word at the tail
  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < res_cnt) q_mem[tail_q + 2'(i)] <= res[i];
      end
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (step) tail_q <= tail_q + res_cnt;
      if (pop) head_q <= head_q + 2'd1;
      count_q <= count_q + (step ? 3'(res_cnt) : 3'd0) - 3'(pop);
    end
  end

  // Room for a full burst of three results
  assign s_axis_tready = (count_q <= 3'd1);

  assign head          = q_mem[head_q];
  assign m_axis_tvalid = (count_q != 3'd0);
  assign m_axis_tdata  = {4'd0, head.length, head.data};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule

// ----- design/ssc_core.sv -----
module ssc_core import ssc_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              mode_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              start_ok_i,
  output res_t [2:0]        res_o,
  output logic [1:0]        res_cnt_o
);

  localparam int unsigned LEN_W = $clog2(BUFFER_BYTES);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(BUFFER_BYTES - 1);

  typedef logic [LEN_W-1:0] len_t;

  len_t   sl_q, sl_d;
  len_t   ls_q, ls_d;
  flags_t fl_q, fl_d;
  res_t [2:0] res;
  logic [1:0] cnt;

  // Append one result word
  function automatic void emit(input kind_e k, input logic [BYTE_W-1:0] d, input len_t l,
                               inout res_t [2:0] r, inout logic [1:0] n);
    r[n] = '{kind: k, data: d, length: LENGTH_W'(l), last: 1'b0};
    n = n + 2'd1;
  endfunction

  function automatic void restart_line(inout flags_t f);
    f.lcc    = 3'd0;
    f.cmatch = 3'b111;
  endfunction

  // Store one byte unless the buffer is full
  function automatic logic store(input logic [BYTE_W-1:0] b, inout len_t sl,
                                 inout flags_t f, inout res_t [2:0] r, inout logic [1:0] n);
    logic ok;
    ok = 1'b0;
    if (sl >= FULL_LEN) begin
      if (!f.ovf_rep) begin
        f.ovf_rep = 1'b1;
        emit(KIND_OVERFLOW, '0, sl, r, n);
      end
    end else begin
      sl = sl + 1'b1;
      emit(KIND_STORE, b, sl, r, n);
      ok = 1'b1;
    end
    return ok;
  endfunction

  // Track command prefix match for a stored byte
  function automatic void note(input logic [BYTE_W-1:0] b, inout flags_t f);
    logic [BYTE_W-1:0] c;
    for (int k = 0; k < NUM_CMD; k++) begin
      c = (f.lcc < 3'd6) ? CMD_TEXT[k][f.lcc] : '0;
      if (f.lcc >= CMD_LEN[k] || f.lcc >= 3'd6 || c != b) f.cmatch[k] = 1'b0;
    end
    if (f.lcc != 3'd7) f.lcc = f.lcc + 3'd1;
  endfunction

  // Lexical tracking of literals and comments
  function automatic void lex(input logic [BYTE_W-1:0] b, inout flags_t f);
    logic [BYTE_W-1:0] close;
    logic              done;
    close = (f.lex == LX_STRLIT) ? CH_DQ : CH_SQ;
    done  = 1'b0;
    if (f.lex == LX_STRLIT || f.lex == LX_CHRLIT) begin
      if (f.esc) f.esc = 1'b0;
      else if (b == CH_BSL) f.esc = 1'b1;
      else if (b == close) f.lex = LX_PLAIN;
    end else if (f.lex == LX_PLAIN) begin
      if (f.slash) begin
        f.slash = 1'b0;
        if (b == CH_SL) begin
          f.lex = LX_REMARK;
          done  = 1'b1;
        end
      end
      if (!done) begin
        if (b == CH_SL) f.slash = 1'b1;
        else if (b == CH_DQ) f.lex = LX_STRLIT;
        else if (b == CH_SQ) f.lex = LX_CHRLIT;
      end
    end
  endfunction

  function automatic void put(input logic [BYTE_W-1:0] b, inout len_t sl,
                              inout flags_t f, inout res_t [2:0] r, inout logic [1:0] n);
    if (store(b, sl, f, r, n)) begin
      note(b, f);
      lex(b, f);
    end
  endfunction

  // Work out the next state and the results of the offered word
  always_comb begin
    len_t   sl;
    len_t   ls;
    flags_t f;
    res_t [2:0] r;
    logic [1:0] n;
    logic   was;
    logic   skip;
    logic   hit;
    sl   = sl_q;
    ls   = ls_q;
    f    = fl_q;
    r    = '0;
    n    = 2'd0;
    was  = 1'b0;
    skip = 1'b0;
    hit  = 1'b0;
    if (mode_i) begin
      if (start_ok_i) f.running = 1'b1;
    end else if (rx_byte_i == CTRL_C) begin
      was = f.running;
      sl  = '0;
      ls  = '0;
      f   = FLAGS_RESET;
      emit(was ? KIND_STOPPED : KIND_CLEARED, '0, '0, r, n);
    end else if (f.swallow_lf && rx_byte_i == CH_LF) begin
      f.swallow_lf = 1'b0;
    end else begin
      f.swallow_lf = 1'b0;
      if (f.running) begin
        emit(KIND_FORWARD, rx_byte_i, sl, r, n);
      end else if (rx_byte_i != CH_CR && rx_byte_i != CH_LF) begin
        // Content byte: drop leading blanks and comment lines
        if (f.line != LN_COMMENT) begin
          unique case (f.line)
            LN_PREFIX: begin
              if (rx_byte_i == CH_SP || rx_byte_i == CH_TAB) begin
                skip = 1'b1;
              end else if (f.lex == LX_PLAIN && rx_byte_i == CH_SL) begin
                f.line = LN_PREFIX_SLASH;
                skip   = 1'b1;
              end else begin
                f.line = LN_BODY;
              end
            end
            LN_PREFIX_SLASH: begin
              if (rx_byte_i == CH_SL) begin
                f.line = LN_COMMENT;
                f.lex  = LX_REMARK;
                skip   = 1'b1;
              end else begin
                put(CH_SL, sl, f, r, n);
                f.line = LN_BODY;
              end
            end
            LN_BODY:    ;
            LN_COMMENT: ;
          endcase
          if (!skip) put(rx_byte_i, sl, f, r, n);
        end
      end else begin
        // Line end: store it, then check for a command line
        if (rx_byte_i == CH_CR) f.swallow_lf = 1'b1;
        if (f.line == LN_PREFIX_SLASH) put(CH_SL, sl, f, r, n);
        void'(store(rx_byte_i, sl, f, r, n));
        if (f.cmd_allowed) begin
          for (int k = 0; k < NUM_CMD; k++) begin
            if (!hit && f.cmatch[k] && f.lcc == CMD_LEN[k]) begin
              hit = 1'b1;
              emit(CMD_KIND[k], '0, ls, r, n);
              if (CMD_KIND[k] == KIND_ERASE) begin
                sl = '0;
                ls = '0;
                f  = FLAGS_RESET;
              end else begin
                sl = ls;
                restart_line(f);
              end
            end
          end
        end
        if (!hit) begin
          if (!(f.lex == LX_STRLIT && f.esc)) f.lex = LX_PLAIN;
          f.esc         = 1'b0;
          f.slash       = 1'b0;
          ls            = sl;
          f.line        = LN_PREFIX;
          f.cmd_allowed = (f.lex == LX_PLAIN);
          restart_line(f);
        end
      end
    end
    // Mark the final result of this word
    if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    sl_d = sl;
    ls_d = ls;
    fl_d = f;
    res  = r;
    cnt  = n;
  end

  // Commit state on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_q <= '0;
      ls_q <= '0;
      fl_q <= FLAGS_RESET;
    end else if (step_i) begin
      sl_q <= sl_d;
      ls_q <= ls_d;
      fl_q <= fl_d;
    end
  end

  assign res_o     = res;
  assign res_cnt_o = cnt;

endmodule

// ----- design/ssc_checker.sv -----
module ssc_checker import ssc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Only stored and forwarded words carry a byte
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_STORE && m_axis_tuser != KIND_FORWARD
    |-> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero data on event word");

  // Clear and stop events report zero length
  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_CLEARED || m_axis_tuser == KIND_STOPPED)
    |-> m_axis_tdata[19:8] == 12'd0)
    else $error("clear event with nonzero length");

  // Command and clear events end the burst of their word
  a_event_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_RUN || m_axis_tuser == KIND_SAVE ||
                      m_axis_tuser == KIND_ERASE || m_axis_tuser == KIND_CLEARED ||
                      m_axis_tuser == KIND_STOPPED)
    |-> m_axis_tlast)
    else $error("event word not marked last");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
        $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready
    |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input word changed while stalled");

endmodule

bind script_source_compactor ssc_checker u_ssc_checker (.*);

// ----- tb/compactor_checker.sv -----
`timescale 1ns / 1ps

module compactor_checker import ssc_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] start_ok, [15:9] zero
  input  logic        s_axis_tuser,   // [0] mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] data, [19:8] length, [23:20] zero
  input  logic [2:0]  m_axis_tuser,   // [2:0] kind
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o
);

  // Command lines, one row per command
  localparam logic [7:0] VERB_TEXT [3][6] = '{
    '{"@", "r", "u", "n", 8'h00, 8'h00},
    '{"@", "s", "a", "v", "e", 8'h00},
    '{"@", "e", "r", "a", "s", "e"}
  };
  localparam int    VERB_LEN  [3] = '{4, 5, 6};
  localparam kind_e VERB_KIND [3] = '{KIND_RUN, KIND_SAVE, KIND_ERASE};

  // Predicted compactor state
  int unsigned stored_len;
  int unsigned line_base;
  bit          running;
  bit          ovf_told;
  bit          skip_lf;
  lex_e        lex;
  line_e       line_st;
  bit          esc;
  bit          slash;
  bit          cmd_ok;
  logic [2:0]  lcc;
  logic [2:0]  cmatch;

  // Results still owed by the block, oldest first
  res_t due_q[$];
  res_t want_r;

  function automatic void queue_result(kind_e k, logic [7:0] d, int unsigned len);
    res_t r;
    r.kind   = k;
    r.data   = d;
    r.length = len[11:0];
    r.last   = 1'b0;
    due_q.push_back(r);
  endfunction

  function automatic void restart_match();
    lcc    = 3'd0;
    cmatch = 3'b111;
  endfunction

  function automatic void clear_state();
    stored_len = 0;
    line_base  = 0;
    running    = 1'b0;
    ovf_told   = 1'b0;
    skip_lf    = 1'b0;
    lex        = LX_PLAIN;
    line_st    = LN_PREFIX;
    esc        = 1'b0;
    slash      = 1'b0;
    cmd_ok     = 1'b1;
    restart_match();
  endfunction

  // Narrow the command candidates by one stored byte
  function automatic void note_byte(logic [7:0] b);
    for (int k = 0; k < 3; k++) begin
      if (lcc >= VERB_LEN[k]) cmatch[k] = 1'b0;
      else if (VERB_TEXT[k][lcc] != b) cmatch[k] = 1'b0;
    end
    if (lcc < 3'd7) lcc = lcc + 3'd1;
  endfunction

  function automatic bit store_byte(logic [7:0] b);
    if (stored_len >= BUFFER_BYTES - 1) begin
      // report a full buffer only once
      if (!ovf_told) begin
        ovf_told = 1'b1;
        queue_result(KIND_OVERFLOW, 8'h00, stored_len);
      end
      return 1'b0;
    end
    stored_len++;
    queue_result(KIND_STORE, b, stored_len);
    return 1'b1;
  endfunction

  // Track literals, escapes and comment openers
  function automatic void lex_step(logic [7:0] b);
    logic [7:0] closer;
    if (lex == LX_REMARK) return;
    if (lex == LX_STRLIT || lex == LX_CHRLIT) begin
      closer = (lex == LX_STRLIT) ? CH_DQ : CH_SQ;
      if (esc) esc = 1'b0;
      else if (b == CH_BSL) esc = 1'b1;
      else if (b == closer) lex = LX_PLAIN;
      return;
    end
    if (slash) begin
      slash = 1'b0;
      if (b == CH_SL) begin
        lex = LX_REMARK;
        return;
      end
    end
    if (b == CH_SL) slash = 1'b1;
    else if (b == CH_DQ) lex = LX_STRLIT;
    else if (b == CH_SQ) lex = LX_CHRLIT;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (store_byte(b)) begin
      note_byte(b);
      lex_step(b);
    end
  endfunction

  // Drop leading blanks and whole-line comments
  function automatic void content_byte(logic [7:0] b);
    if (line_st == LN_COMMENT) return;
    if (line_st == LN_PREFIX) begin
      if (b == CH_SP || b == CH_TAB) return;
      if (lex == LX_PLAIN && b == CH_SL) begin
        line_st = LN_PREFIX_SLASH;
        return;
      end
      line_st = LN_BODY;
    end else if (line_st == LN_PREFIX_SLASH) begin
      if (b == CH_SL) begin
        line_st = LN_COMMENT;
        lex     = LX_REMARK;
        return;
      end
      put_byte(CH_SL);
      line_st = LN_BODY;
    end
    put_byte(b);
  endfunction

  function automatic void newline_byte(logic [7:0] b);
    if (b == CH_CR) skip_lf = 1'b1;
    if (line_st == LN_PREFIX_SLASH) put_byte(CH_SL);
    void'(store_byte(b));

    // A line that is exactly a command rewinds to its start; erase clears all state
    if (cmd_ok) begin
      for (int k = 0; k < 3; k++) begin
        if (cmatch[k] && lcc == VERB_LEN[k]) begin
          queue_result(VERB_KIND[k], 8'h00, line_base);
          if (VERB_KIND[k] == KIND_ERASE) begin
            clear_state();
          end else begin
            stored_len = line_base;
            restart_match();
          end
          return;
        end
      end
    end

    // Backslash-newline keeps a string open
    if (!(lex == LX_STRLIT && esc)) lex = LX_PLAIN;
    esc       = 1'b0;
    slash     = 1'b0;
    line_base = stored_len;
    line_st   = LN_PREFIX;
    cmd_ok    = (lex == LX_PLAIN);
    restart_match();
  endfunction

  // Predict the results of one accepted word
  function automatic void compact_word(bit mode, logic [7:0] b, bit ok);
    int   prior_n;
    bit   was;
    res_t r;
    prior_n = due_q.size();
    if (mode) begin
      if (ok) running = 1'b1;
      return;
    end
    if (b == CTRL_C) begin
      was = running;
      clear_state();
      if (was) queue_result(KIND_STOPPED, 8'h00, 0);
      else queue_result(KIND_CLEARED, 8'h00, 0);
    end else if (skip_lf && b == CH_LF) begin
      skip_lf = 1'b0;
    end else begin
      skip_lf = 1'b0;
      if (running) queue_result(KIND_FORWARD, b, stored_len);
      else if (b != CH_CR && b != CH_LF) content_byte(b);
      else newline_byte(b);
    end
    // mark the final result of this word
    if (due_q.size() > prior_n) begin
      r = due_q.pop_back();
      r.last = 1'b1;
      due_q.push_back(r);
    end
  endfunction

  // Predict on input words, compare output words against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
      due_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        compact_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          $error("result with nothing due: kind %0d data %0h length %0d last %0b",
                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[19:8], m_axis_tlast);
          errors_o++;
        end else begin
          want_r = due_q.pop_front();
          if (m_axis_tuser !== want_r.kind) begin
            $error("kind: expected %0d, actual %0d", want_r.kind, m_axis_tuser);
            errors_o++;
          end
          if (m_axis_tdata[7:0] !== want_r.data) begin
            $error("data: expected %0h, actual %0h", want_r.data, m_axis_tdata[7:0]);
            errors_o++;
          end
          if (m_axis_tdata[19:8] !== want_r.length) begin
            $error("length: expected %0d, actual %0d", want_r.length, m_axis_tdata[19:8]);
            errors_o++;
          end
          if (m_axis_tlast !== want_r.last) begin
            $error("last: expected %0b, actual %0b", want_r.last, m_axis_tlast);
            errors_o++;
          end
        end
      end
      pending_o = due_q.size();
    end
  end

endmodule

// ----- tb/script_source_compactor_test.sv -----
`timescale 1ns / 1ps

module script_source_compactor_test import ssc_pkg::*;;

  // Buffer size as the block is built by default
  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int RANDOM_WORDS = 370;
  localparam int CALM_WORDS   = 60;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [23:0] m_tdata;
  wire  [2:0]  m_tuser;
  wire         m_tlast;

  int errors;
  int pending;
  int words_sent  = 0;
  int cycle_count = 0;
  bit idle_on     = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  bit hold_fired  = 1'b0;
  int total_words;

  string verbs [3] = '{"@run", "@save", "@erase"};

  script_source_compactor #(.BUFFER_BYTES(BUFFER_BYTES)) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  compactor_checker #(.BUFFER_BYTES(BUFFER_BYTES)) result_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one word, with an occasional idle burst ahead of it
  task automatic send_word(input bit mode, input logic [7:0] b, input bit ok);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'd0, ok, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_outcome(input bit ok);
    send_word(1'b1, 8'($urandom_range(0, 255)), ok);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_indent();
    repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 3))
      0, 1: send_byte(CH_LF);
      2: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      default: send_byte(CH_CR);
    endcase
  endtask

  // Source text biased toward the characters the lexer cares about
  function automatic logic [7:0] code_char();
    case ($urandom_range(0, 11))
      0: return CH_DQ;
      1: return CH_SQ;
      2: return CH_BSL;
      3: return CH_SL;
      4: return CH_SP;
      5: return "@";
      default: return 8'($urandom_range(8'h21, 8'h7e));
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    string verb;
    int    pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: blanks, comment line, CR-LF, lone slash, string continuation,
    // a run command, a running script, stop and clear
    send_outcome(1'b0);
    send_byte(CH_SP);
    send_byte(CH_TAB);
    send_text("//q");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_SL);
    send_byte(CH_LF);
    send_byte(CH_DQ);
    send_byte(CH_BSL);
    send_byte(CH_LF);
    send_byte(CH_DQ);
    send_byte(CH_LF);
    send_text("@run");
    send_byte(CH_LF);
    send_outcome(1'b1);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(CTRL_C);
    send_byte(CTRL_C);

    // Random: mostly well-formed lines, some sessions and noise
    total_words = words_sent + RANDOM_WORDS;
    while (words_sent < total_words) begin
      if (words_sent >= total_words - CALM_WORDS) idle_on = 1'b0;
      if (!hold_fired && words_sent >= total_words - RANDOM_WORDS + 120) begin
        hold_fired = 1'b1;
        hold_req   = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_indent();
        repeat ($urandom_range(1, 10)) send_byte(code_char());
        send_eol();
      end else if (pick < 58) begin
        if ($urandom_range(0, 1)) send_indent();
        verb = verbs[$urandom_range(0, 2)];
        case ($urandom_range(0, 9))
          0, 1: send_text(verb.substr(0, verb.len() - 2));
          2: begin
            send_text(verb);
            send_byte(code_char());
          end
          default: send_text(verb);
        endcase
        send_eol();
        if ($urandom_range(0, 9) < 6) send_outcome($urandom_range(0, 9) < 3);
      end else if (pick < 68) begin
        send_indent();
        send_text("//");
        repeat ($urandom_range(0, 5)) send_byte(code_char());
        send_eol();
      end else if (pick < 76) begin
        send_outcome(1'b1);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        send_byte(CTRL_C);
      end else if (pick < 84) begin
        send_byte(CTRL_C);
      end else if (pick < 92) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_outcome(1'($urandom_range(0, 1)));
      end
    end
    s_tvalid <= 1'b0;

    // Drain, then allow for late stray results
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
